// File: rtl/core/vwbp_pkg.sv
// ----------------------------------------------------------------------------
// vwbp_pkg
// Shared types and constants for the variable-width bit packer: field widths,
// command codes and the records passed to and from the shared step unit.
// ----------------------------------------------------------------------------
package vwbp_pkg;

  // Field widths
  localparam int unsigned ValueW   = 64;
  localparam int unsigned BitsW    = 7;
  localparam int unsigned IndexW   = 16;
  localparam int unsigned FreeW    = 4;

  // Largest bit count taken from one write; larger counts are clamped to it
  localparam logic [BitsW-1:0] MaxValueBits = 7'd64;

  // Bits in one output byte, as a free-bit count
  localparam logic [FreeW-1:0] ByteBits = 4'd8;

  // Capacity register value after reset
  localparam logic [IndexW-1:0] CapacityReset = 16'hFFFF;

  // Request command codes
  typedef enum logic {
    CmdWrite = 1'b0,
    CmdFlush = 1'b1
  } cmd_e;

  // Packer state seen by the step unit
  typedef struct packed {
    logic [7:0]        partial;
    logic [FreeW-1:0]  free;
    logic [BitsW-1:0]  rem;
    logic [ValueW-1:0] value;
  } step_in_t;

  // Outcome of one packing step
  typedef struct packed {
    logic              send;     // the held full byte leaves in this step
    logic              last;     // that byte is the final one of the request
    logic              done;     // all bits of the request are placed
    logic [7:0]        partial;
    logic [FreeW-1:0]  free;
    logic [BitsW-1:0]  rem;
  } step_out_t;

endpackage

// File: rtl/core/vwbp_if.sv
// ----------------------------------------------------------------------------
// vwbp_in_if / vwbp_out_if
// Valid/ready channels of the bit packer: request channel carrying commands
// and values, result channel carrying packed bytes with their position.
// ----------------------------------------------------------------------------
interface vwbp_in_if;
  logic                          valid;
  logic                          ready;
  logic                          command;
  logic [vwbp_pkg::ValueW-1:0]   value;
  logic [vwbp_pkg::BitsW-1:0]    value_bits;

  modport source (output valid, command, value, value_bits, input ready);
  modport sink   (input valid, command, value, value_bits, output ready);
endinterface

interface vwbp_out_if;
  logic                          valid;
  logic                          ready;
  logic [7:0]                    out_byte;
  logic [vwbp_pkg::IndexW-1:0]   byte_index;
  logic                          overflow;
  logic                          last;

  modport source (output valid, out_byte, byte_index, overflow, last, input ready);
  modport sink   (input valid, out_byte, byte_index, overflow, last, output ready);
endinterface

// File: rtl/core/vwbp_step_unit.sv
// ----------------------------------------------------------------------------
// vwbp_step_unit
// One packing step: sends a held full byte if there is one, then places as
// many pending value bits as fit into the partial byte via a 64-bit shifter.
// ----------------------------------------------------------------------------
module vwbp_step_unit (
  input  vwbp_pkg::step_in_t  step_i,
  output vwbp_pkg::step_out_t step_o
);

  logic                           empty;
  logic [7:0]                     p0;
  logic [vwbp_pkg::FreeW-1:0]     f0;
  logic                           fits;
  logic [vwbp_pkg::FreeW-1:0]     rem_lo;
  logic [vwbp_pkg::BitsW-1:0]     rem_left;
  logic [vwbp_pkg::ValueW-1:0]    shifted;
  logic [7:0]                     part;

  always_comb begin
    // a full byte is flushed first, leaving an empty byte to fill
    empty    = (step_i.free == '0);
    p0       = empty ? 8'd0 : step_i.partial;
    f0       = empty ? vwbp_pkg::ByteBits : step_i.free;
    fits     = ({3'd0, f0} >= step_i.rem);
    rem_lo   = step_i.rem[vwbp_pkg::FreeW-1:0];
    rem_left = step_i.rem - {3'd0, f0};

    // shared shifter: next bits of the value, MSB first
    shifted  = step_i.value >> rem_left;
    part     = step_i.value[7:0] & (8'hFF >> (vwbp_pkg::ByteBits - rem_lo));

    step_o.send = empty;
    step_o.last = (step_i.rem <= {3'd0, vwbp_pkg::ByteBits});

    if (fits) begin
      // remaining bits all fit in the current byte
      step_o.done    = 1'b1;
      step_o.partial = p0 | 8'(part << (f0 - rem_lo));
      step_o.free    = f0 - rem_lo;
      step_o.rem     = '0;
    end else begin
      // fill the free low bits, byte becomes full
      step_o.done    = 1'b0;
      step_o.partial = p0 | (shifted[7:0] & (8'hFF >> (vwbp_pkg::ByteBits - f0)));
      step_o.free    = '0;
      step_o.rem     = rem_left;
    end
  end

endmodule

// File: rtl/core/variable_width_bit_packer_core.sv
// Sequence: a write is accepted in the idle state, then the single shared step
//   unit runs one step per byte touched; a flush of a pending byte is accepted,
//   then the byte is sent; an empty flush or a zero-bit write is only accepted.
// A new request is taken only once the previous one is finished; result
//   stalls hold the steps and sends. Reset: asynchronous, active low; empties the partial
//   byte, zeroes the byte position and sets the capacity register to 65535.
// ----------------------------------------------------------------------------
// variable_width_bit_packer_core
// Packs values of 1 to 64 bits MSB first into a byte stream. Full bytes are
// sent lazily; a flush sends the pending byte, zero padded, and empties it.
// ----------------------------------------------------------------------------
module variable_width_bit_packer_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [vwbp_pkg::IndexW-1:0] cfg_wdata_i,
  vwbp_in_if.sink                     req_i,
  vwbp_out_if.source                  res_o
);

  typedef enum logic [2:0] {
    StIdle  = 3'b001,
    StWrite = 3'b010,
    StFlush = 3'b100
  } state_e;

  state_e                          state_q, state_d;
  logic [vwbp_pkg::IndexW-1:0]     cap_q;
  logic [7:0]                      partial_q, partial_d;
  logic [vwbp_pkg::FreeW-1:0]      free_q, free_d;
  logic [vwbp_pkg::IndexW-1:0]     pos_q, pos_d;
  logic [vwbp_pkg::BitsW-1:0]      rem_q, rem_d;
  logic [vwbp_pkg::ValueW-1:0]     value_q, value_d;

  logic                            res_valid_q, res_valid_d;
  logic [7:0]                      res_byte_q, res_byte_d;
  logic [vwbp_pkg::IndexW-1:0]     res_index_q, res_index_d;
  logic                            res_ovf_q, res_ovf_d;
  logic                            res_last_q, res_last_d;

  logic                            req_fire;
  logic                            res_slot;
  logic [vwbp_pkg::BitsW-1:0]      bits_clamped;
  vwbp_pkg::step_in_t              step_in;
  vwbp_pkg::step_out_t             step_out;

  // shared packing step
  assign step_in = '{partial: partial_q, free: free_q, rem: rem_q, value: value_q};

  vwbp_step_unit u_step (
    .step_i (step_in),
    .step_o (step_out)
  );

  assign req_i.ready = (state_q == StIdle);
  assign req_fire    = req_i.valid && req_i.ready;
  // output register can take a byte this cycle
  assign res_slot    = !res_valid_q || res_o.ready;

  assign bits_clamped = (req_i.value_bits > vwbp_pkg::MaxValueBits) ?
                        vwbp_pkg::MaxValueBits : req_i.value_bits;

  // sequencer
  always_comb begin
    state_d     = state_q;
    partial_d   = partial_q;
    free_d      = free_q;
    pos_d       = pos_q;
    rem_d       = rem_q;
    value_d     = value_q;
    res_valid_d = res_valid_q && !res_o.ready;
    res_byte_d  = res_byte_q;
    res_index_d = res_index_q;
    res_ovf_d   = res_ovf_q;
    res_last_d  = res_last_q;

    unique case (state_q)
      StIdle: begin
        if (req_fire) begin
          if (req_i.command == vwbp_pkg::CmdFlush) begin
            if (free_q < vwbp_pkg::ByteBits) begin
              state_d = StFlush;
            end
          end else if (req_i.value_bits != '0) begin
            value_d = req_i.value;
            rem_d   = bits_clamped;
            state_d = StWrite;
          end
        end
      end
      StFlush: begin
        if (res_slot) begin
          res_valid_d = 1'b1;
          res_byte_d  = partial_q;
          res_index_d = pos_q;
          res_ovf_d   = (pos_q >= cap_q);
          res_last_d  = 1'b1;
          pos_d       = pos_q + 16'd1;
          partial_d   = '0;
          free_d      = vwbp_pkg::ByteBits;
          state_d     = StIdle;
        end
      end
      StWrite: begin
        // hold the step while a byte must leave and the output is occupied
        if (!step_out.send || res_slot) begin
          if (step_out.send) begin
            res_valid_d = 1'b1;
            res_byte_d  = partial_q;
            res_index_d = pos_q;
            res_ovf_d   = (pos_q >= cap_q);
            res_last_d  = step_out.last;
            pos_d       = pos_q + 16'd1;
          end
          partial_d = step_out.partial;
          free_d    = step_out.free;
          rem_d     = step_out.rem;
          if (step_out.done) begin
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cap_q       <= vwbp_pkg::CapacityReset;
      partial_q   <= '0;
      free_q      <= vwbp_pkg::ByteBits;
      pos_q       <= '0;
      rem_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      partial_q   <= partial_d;
      free_q      <= free_d;
      pos_q       <= pos_d;
      rem_q       <= rem_d;
      res_valid_q <= res_valid_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    value_q     <= value_d;
    res_byte_q  <= res_byte_d;
    res_index_q <= res_index_d;
    res_ovf_q   <= res_ovf_d;
    res_last_q  <= res_last_d;
  end

  assign res_o.valid      = res_valid_q;
  assign res_o.out_byte   = res_byte_q;
  assign res_o.byte_index = res_index_q;
  assign res_o.overflow   = res_ovf_q;
  assign res_o.last       = res_last_q;

endmodule

// File: rtl/core/vwbp_checker.sv
// ----------------------------------------------------------------------------
// vwbp_checker
// Port-level checks of the bit packer: result hold, byte ordering, overflow
// flag against the capacity register, and request blocking mid-request.
// ----------------------------------------------------------------------------
module vwbp_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        cfg_we_i,
  input logic [vwbp_pkg::IndexW-1:0] cfg_wdata_i,
  input logic                        req_ready_i,
  input logic                        res_valid_i,
  input logic                        res_ready_i,
  input logic [7:0]                  res_byte_i,
  input logic [vwbp_pkg::IndexW-1:0] res_index_i,
  input logic                        res_ovf_i,
  input logic                        res_last_i
);

  logic [vwbp_pkg::IndexW-1:0] cap_q;
  logic [vwbp_pkg::IndexW-1:0] last_idx_q;
  logic                        seen_q;

  // shadow of capacity and of the last delivered position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q      <= vwbp_pkg::CapacityReset;
      last_idx_q <= '0;
      seen_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (res_valid_i && res_ready_i) begin
        last_idx_q <= res_index_i;
        seen_q     <= 1'b1;
      end
    end
  end

  // a stalled result keeps its byte
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_byte_i))
    else $error("result byte dropped or changed while stalled");

  // delivered bytes carry consecutive positions
  a_res_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_ready_i && seen_q |-> res_index_i == last_idx_q + 16'd1)
    else $error("byte position not consecutive");

  // overflow agrees with the capacity register
  a_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> res_ovf_i == (res_index_i >= cap_q))
    else $error("overflow flag wrong");

  // no new request while a request still has bytes to come
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_last_i |-> !req_ready_i)
    else $error("request accepted before previous one finished");

endmodule

bind variable_width_bit_packer_core vwbp_checker u_vwbp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cfg_we_i    (cfg_we_i),
  .cfg_wdata_i (cfg_wdata_i),
  .req_ready_i (req_i.ready),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .res_byte_i  (res_o.out_byte),
  .res_index_i (res_o.byte_index),
  .res_ovf_i   (res_o.overflow),
  .res_last_i  (res_o.last)
);
